// File: src/assert_macros.svh
// assertion helpers used by the scanner core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MSAFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MSAFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/msafs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msafs_pkg
// Constants and types of the magic word frame scanner.
// ----------------------------------------------------------------------------
package msafs_pkg;

	localparam int unsigned FRAME_LEN   = 13;
	localparam int unsigned MAGIC_LEN   = 4;
	localparam int unsigned MAGIC_IDX_W = $clog2(MAGIC_LEN);
	localparam int unsigned POS_W       = $clog2(FRAME_LEN);

	localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h4A, 8'h50, 8'h47, 8'h55};
	localparam logic [7:0] VERSION_BYTE = 8'h01;
	localparam logic [7:0] CMD_ACK      = 8'h80;
	localparam logic [7:0] CMD_NACK     = 8'h81;

	localparam logic [POS_W-1:0] POS_MAGIC_END = POS_W'(MAGIC_LEN);
	localparam logic [POS_W-1:0] POS_VER       = POS_W'(4);
	localparam logic [POS_W-1:0] POS_CMD       = POS_W'(5);
	localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_LEN - 1);

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} drn_cell_t;

	typedef struct packed {
		logic load;
		logic pop;
	} drn_ctl_t;

endpackage

// File: src/msafs_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msafs_rx_if
// Byte channel from the serial receiver.
// ----------------------------------------------------------------------------
interface msafs_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/msafs_frame_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msafs_frame_if
// Channel of validated frame bytes, last byte marked.
// ----------------------------------------------------------------------------
interface msafs_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// File: src/msafs_col_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msafs_col_cell
// One byte cell of the collect chain; shifts on every accepted beat.
// ----------------------------------------------------------------------------
module msafs_col_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

// File: src/msafs_drn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msafs_drn_cell
// One cell of the drain chain; loaded in parallel, moves toward the head on pop.
// ----------------------------------------------------------------------------
module msafs_drn_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msafs_pkg::drn_ctl_t  ctl,
	input  msafs_pkg::drn_cell_t load_val,
	input  msafs_pkg::drn_cell_t next,
	output msafs_pkg::drn_cell_t q
);

	msafs_pkg::drn_cell_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (ctl.load) begin
			cell_q <= load_val;
		end else if (ctl.pop) begin
			cell_q <= next;
		end
	end

	assign q = cell_q;

endmodule

// File: src/magic_sync_ack_frame_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_sync_ack_frame_scanner_core
// Hunts for the magic word in a byte stream and passes on complete ack / nack
// frames whose version and command bytes check out.
// ----------------------------------------------------------------------------
// usage:
//   rx carries one received byte per beat; frame carries the bytes of each
//   valid frame, magic first, with last_byte set on the final beat.
//   bytes shift through a chain of collect cells; the byte that completes a
//   valid frame copies the chain into a chain of drain cells in parallel.
//   the first frame beat is offered the cycle after the completing byte is
//   taken; the frame then leaves at one beat per cycle while frame.ready is high.
//   throughput: one rx beat per cycle. rx.ready drops only for the byte that
//   would complete a frame while the previous frame still has beats left
//   beyond a last beat that is taken in the same cycle.
//   invalid frames are dropped without any frame beat and the hunt restarts.
//   reset clears the position counter and empties the drain chain; nothing
//   needs a clearing pass. when the receiver stalls, the head beat holds and
//   body bytes keep arriving until the next frame would complete.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module magic_sync_ack_frame_scanner_core (
	input  logic                 clk,
	input  logic                 arst_n,
	msafs_rx_if.sink             rx,
	msafs_frame_if.source        frame
);

	localparam int unsigned FL = msafs_pkg::FRAME_LEN;

	logic [msafs_pkg::POS_W-1:0] pos_q;
	logic                        ver_ok_q;
	logic                        cmd_ok_q;
	logic [7:0]                  col_q [FL-1];
	msafs_pkg::drn_cell_t        drn_q [FL];
	msafs_pkg::drn_ctl_t         drn_ctl;
	logic                        acc;
	logic                        complete;
	logic                        cmd_ok_now;
	logic                        magic_hit;
	logic                        is_cmd;
	logic                        head_leaving;

	assign acc       = rx.valid && rx.ready;
	// the last beat leaving this cycle frees the drain chain for a new load
	assign head_leaving = drn_ctl.pop && drn_q[0].last;
	assign rx.ready  = !((pos_q == msafs_pkg::POS_LAST) && drn_q[0].valid && !head_leaving);
	assign magic_hit = rx.rx_byte == msafs_pkg::MAGIC[pos_q[msafs_pkg::MAGIC_IDX_W-1:0]];
	assign is_cmd    = (rx.rx_byte == msafs_pkg::CMD_ACK) ||
	                   (rx.rx_byte == msafs_pkg::CMD_NACK);
	assign cmd_ok_now = (pos_q == msafs_pkg::POS_CMD) ? is_cmd : cmd_ok_q;
	assign complete   = acc && (pos_q == msafs_pkg::POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ver_ok_q <= 1'b0;
			cmd_ok_q <= 1'b0;
		end else if (acc) begin
			if (pos_q < msafs_pkg::POS_MAGIC_END) begin
				if (magic_hit) begin
					pos_q <= pos_q + 1'b1;
				end else if (rx.rx_byte == msafs_pkg::MAGIC[0]) begin
					// mismatching byte may itself start a new magic word
					pos_q <= msafs_pkg::POS_W'(1);
				end else begin
					pos_q <= '0;
				end
			end else if (pos_q == msafs_pkg::POS_LAST) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
			if (pos_q == msafs_pkg::POS_VER) begin
				ver_ok_q <= rx.rx_byte == msafs_pkg::VERSION_BYTE;
			end
			if (pos_q == msafs_pkg::POS_CMD) begin
				cmd_ok_q <= is_cmd;
			end
		end
	end

	// collect chain: cell 0 holds the newest byte
	for (genvar i = 0; i < FL - 1; i++) begin : g_col
		if (i == 0) begin : g_head
			msafs_col_cell u_cell (
				.clk   (clk),
				.shift (acc),
				.d     (rx.rx_byte),
				.q     (col_q[i])
			);
		end else begin : g_body
			msafs_col_cell u_cell (
				.clk   (clk),
				.shift (acc),
				.d     (col_q[i-1]),
				.q     (col_q[i])
			);
		end
	end

	assign drn_ctl.load = complete && ver_ok_q && cmd_ok_now;
	assign drn_ctl.pop  = frame.valid && frame.ready;

	// drain chain: cell 0 is the head beat
	for (genvar i = 0; i < FL; i++) begin : g_drn
		msafs_pkg::drn_cell_t load_val;
		msafs_pkg::drn_cell_t next;

		if (i == FL - 1) begin : g_tail
			assign load_val = '{valid: 1'b1, last: 1'b1, data: rx.rx_byte};
			assign next     = '0;
		end else begin : g_mid
			assign load_val = '{valid: 1'b1, last: 1'b0, data: col_q[FL-2-i]};
			assign next     = drn_q[i+1];
		end

		msafs_drn_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (drn_ctl),
			.load_val (load_val),
			.next     (next),
			.q        (drn_q[i])
		);
	end

	assign frame.valid      = drn_q[0].valid;
	assign frame.frame_byte = drn_q[0].data;
	assign frame.last_byte  = drn_q[0].last;

	`MSAFS_ASSERT_IMP(a_stall_cause, !rx.ready, drn_q[0].valid, "rx stalled with no frame draining")
	`MSAFS_ASSERT_IMP(a_drain_packed, drn_q[1].valid, drn_q[0].valid, "hole at drain head")
	`MSAFS_ASSERT_NXT(a_last_empties, head_leaving && !drn_ctl.load, !frame.valid, "beat after last beat")
	`MSAFS_ASSERT_IMP(a_load_empty, drn_ctl.load, !drn_q[0].valid || head_leaving, "load over busy drain")

endmodule
